### rtl/ikd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ikd_pkg: shared types and constants of the iambic keyer with decoder
// State encoding, register map, timing widths and the Morse decode table.
// ----------------------------------------------------------------------------
package ikd_pkg;

    localparam int DIT_W   = 11;
    localparam int TIMER_W = 13;
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [DIT_W-1:0]  DIT_TIME_RESET = 11'd60;
    localparam logic [CODE_W-1:0] CODE_START     = 8'hFE;

    // Register indexes, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_DIT_TIME = 2'd0,
        REG_MODE_B   = 2'd1,
        REG_SIDETONE = 2'd2,
        REG_UNUSED   = 2'd3
    } t_reg_index;

    typedef enum logic [2:0] {
        ST_IDLE          = 3'd0,
        ST_CHK_DIT       = 3'd1,
        ST_CHK_DAH       = 3'd2,
        ST_KEYED_PREP    = 3'd3,
        ST_KEYED         = 3'd4,
        ST_INTER_ELEMENT = 3'd5,
        ST_PRE_IDLE      = 3'd6
    } t_keyer_state;

    // Code byte to ASCII. Unknown codes give a question mark.
    function automatic logic [CHAR_W-1:0] decode_code(input logic [CODE_W-1:0] code);
        logic [7:0] ch;
        case (code)
            8'hF9: ch = "A";
            8'hE8: ch = "B";
            8'hEA: ch = "C";
            8'hF4: ch = "D";
            8'hFC: ch = "E";
            8'hE2: ch = "F";
            8'hF6: ch = "G";
            8'hE0: ch = "H";
            8'hF8: ch = "I";
            8'hE7: ch = "J";
            8'hF5: ch = "K";
            8'hE4: ch = "L";
            8'hFB: ch = "M";
            8'hFA: ch = "N";
            8'hF7: ch = "O";
            8'hE6: ch = "P";
            8'hED: ch = "Q";
            8'hF2: ch = "R";
            8'hF0: ch = "S";
            8'hFD: ch = "T";
            8'hF1: ch = "U";
            8'hE1: ch = "V";
            8'hF3: ch = "W";
            8'hE9: ch = "X";
            8'hEB: ch = "Y";
            8'hEC: ch = "Z";
            8'hDF: ch = "0";
            8'hCF: ch = "1";
            8'hC7: ch = "2";
            8'hC3: ch = "3";
            8'hC1: ch = "4";
            8'hC0: ch = "5";
            8'hD0: ch = "6";
            8'hD8: ch = "7";
            8'hDC: ch = "8";
            8'hDE: ch = "9";
            8'hD2: ch = "/";
            8'h8C: ch = "?";
            8'hCA: ch = "*";
            8'h00: ch = "#";
            8'hEF: ch = " ";
            default: ch = "?";
        endcase
        return ch[CHAR_W-1:0];
    endfunction

endpackage

### rtl/iambic_keyer_with_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_keyer_with_decoder: iambic A/B Morse keyer with character decoder
// Seven-state keyer with paddle latches, element timing and ASCII decode.
// ----------------------------------------------------------------------------
// Each accepted item is one scan of the paddles plus a millisecond tick flag,
// and each item yields exactly one result item, registered: the key level,
// the sidetone level and, when a character has just ended, its ASCII code.
// The block takes one item per clock cycle; the whole keyer step is a single
// pass of logic from the state registers into the result register, which is
// the only stage between the two channels, so o_in_ready stays high unless
// a finished result is waiting and the output side is not taking it.
// A dit keys for dit_time_ms ticks and a dah for three times that; each
// interval actually ends on the tick after its count runs out. Configuration
// is written over the APB port (dit time at 0x0, mode B at 0x4, sidetone
// enable at 0x8) and must only be changed while no item is in flight.
module iambic_keyer_with_decoder (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ikd_pkg::ADDR_W-1:0]  paddr,
    input  logic [ikd_pkg::DATA_W-1:0]  pwdata,
    output logic [ikd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    // Input channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_dit_pressed,
    input  logic                        i_dah_pressed,
    input  logic                        i_tick,
    // Output channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_key_down,
    output logic                        o_sidetone_on,
    output logic                        o_char_valid,
    output logic [ikd_pkg::CHAR_W-1:0]  o_char_code
);
    import ikd_pkg::*;

    // Configuration registers.
    logic [DIT_W-1:0]   r_dit_time;
    logic               r_mode_b;
    logic               r_sidetone_en;

    // Keyer state.
    t_keyer_state       r_state, n_state;
    logic               r_dit_latch, n_dit_latch;
    logic               r_dah_latch, n_dah_latch;
    logic               r_dit_prog, n_dit_prog;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [CODE_W-1:0]  r_code, n_code;
    logic               r_key_level, n_key_level;

    // Result register.
    logic               r_out_valid;
    logic               r_key_down, r_sidetone, r_char_valid;
    logic [CHAR_W-1:0]  r_char_code;
    logic               n_char_valid;
    logic [CHAR_W-1:0]  n_char_code;

    logic               in_accept;
    logic               cfg_write;
    logic               expired;
    logic               any_paddle;
    logic [TIMER_W-1:0] dit_ticks, two_dits, three_dits;
    t_reg_index         cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = t_reg_index'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite;

    // Register writes ignore the upper data bits and the unused slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dit_time    <= DIT_TIME_RESET;
            r_mode_b      <= 1'b1;
            r_sidetone_en <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_DIT_TIME: r_dit_time    <= pwdata[DIT_W-1:0];
                REG_MODE_B:   r_mode_b      <= pwdata[0];
                REG_SIDETONE: r_sidetone_en <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_DIT_TIME: prdata = {{(DATA_W-DIT_W){1'b0}}, r_dit_time};
            REG_MODE_B:   prdata = {{(DATA_W-1){1'b0}}, r_mode_b};
            REG_SIDETONE: prdata = {{(DATA_W-1){1'b0}}, r_sidetone_en};
            default:      prdata = '0;
        endcase
    end

    // The result register frees up when its item is taken in the same cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Interval lengths; three dits of the widest dit time still fit in 13 bits.
    assign dit_ticks  = {{(TIMER_W-DIT_W){1'b0}}, r_dit_time};
    assign two_dits   = {dit_ticks[TIMER_W-2:0], 1'b0};
    assign three_dits = two_dits + dit_ticks;

    // A tick with the counter at zero ends the interval.
    assign expired    = i_tick && (r_timer == '0);
    assign any_paddle = i_dit_pressed || i_dah_pressed || r_dit_latch || r_dah_latch;

    always_comb begin
        n_state      = r_state;
        n_dit_latch  = r_dit_latch;
        n_dah_latch  = r_dah_latch;
        n_dit_prog   = r_dit_prog;
        n_timer      = r_timer;
        n_code       = r_code;
        n_key_level  = r_key_level;
        n_char_valid = 1'b0;
        n_char_code  = '0;
        case (r_state)
            ST_CHK_DIT: begin
                if (r_dit_latch) begin
                    n_dit_prog = 1'b1;
                    n_timer    = dit_ticks;
                    n_code     = {r_code[CODE_W-2:0], 1'b0};
                    n_state    = ST_KEYED_PREP;
                end else begin
                    n_state = ST_CHK_DAH;
                end
            end
            ST_CHK_DAH: begin
                if (r_dah_latch) begin
                    n_timer = three_dits;
                    n_code  = {r_code[CODE_W-2:0], 1'b1};
                    n_state = ST_KEYED_PREP;
                end else begin
                    n_timer = two_dits;
                    n_state = ST_PRE_IDLE;
                end
            end
            ST_KEYED_PREP: begin
                n_key_level = 1'b1;
                n_dit_latch = 1'b0;
                n_dah_latch = 1'b0;
                n_state     = ST_KEYED;
            end
            ST_KEYED: begin
                if (expired) begin
                    n_key_level = 1'b0;
                    n_timer     = dit_ticks;
                    n_state     = ST_INTER_ELEMENT;
                end else begin
                    if (i_tick) begin
                        n_timer = r_timer - TIMER_W'(1);
                    end
                    // Mode B keeps listening to the paddles while keyed.
                    if (r_mode_b) begin
                        n_dit_latch = r_dit_latch || i_dit_pressed;
                        n_dah_latch = r_dah_latch || i_dah_pressed;
                    end
                end
            end
            ST_INTER_ELEMENT: begin
                n_dit_latch = r_dit_latch || i_dit_pressed;
                n_dah_latch = r_dah_latch || i_dah_pressed;
                if (expired) begin
                    if (r_dit_prog) begin
                        n_dit_latch = 1'b0;
                        n_dit_prog  = 1'b0;
                        n_state     = ST_CHK_DAH;
                    end else begin
                        n_dah_latch = 1'b0;
                        n_timer     = two_dits;
                        n_state     = ST_PRE_IDLE;
                    end
                end else if (i_tick) begin
                    n_timer = r_timer - TIMER_W'(1);
                end
            end
            ST_PRE_IDLE: begin
                if (any_paddle) begin
                    n_dit_latch = r_dit_latch || i_dit_pressed;
                    n_dah_latch = r_dah_latch || i_dah_pressed;
                    n_state     = ST_CHK_DIT;
                end else if (expired) begin
                    n_char_valid = 1'b1;
                    n_char_code  = decode_code(r_code);
                    n_state      = ST_IDLE;
                end else if (i_tick) begin
                    n_timer = r_timer - TIMER_W'(1);
                end
            end
            default: begin
                // Idle, and any unused encoding, waits for a paddle.
                if (any_paddle) begin
                    n_dit_latch = r_dit_latch || i_dit_pressed;
                    n_dah_latch = r_dah_latch || i_dah_pressed;
                    n_code      = CODE_START;
                    n_state     = ST_CHK_DIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dit_latch <= 1'b0;
            r_dah_latch <= 1'b0;
            r_dit_prog  <= 1'b0;
            r_timer     <= '0;
            r_code      <= CODE_START;
            r_key_level <= 1'b0;
        end else if (in_accept) begin
            r_state     <= n_state;
            r_dit_latch <= n_dit_latch;
            r_dah_latch <= n_dah_latch;
            r_dit_prog  <= n_dit_prog;
            r_timer     <= n_timer;
            r_code      <= n_code;
            r_key_level <= n_key_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; the sidetone enable is sampled with the item.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key_down   <= n_key_level;
            r_sidetone   <= n_key_level && r_sidetone_en;
            r_char_valid <= n_char_valid;
            r_char_code  <= n_char_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_key_down    = r_key_down;
    assign o_sidetone_on = r_sidetone;
    assign o_char_valid  = r_char_valid;
    assign o_char_code   = r_char_code;

    // The key is down exactly while the machine sits in the keyed state.
    a_key_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_level == (r_state == ST_KEYED))
        else $error("key level disagrees with keyer state");

    // A character only completes with the key up.
    a_char_key_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_char_valid) |-> !o_key_down)
        else $error("character completed while keyed");

    // Sidetone never sounds without the key.
    a_sidetone_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sidetone_on) |-> o_key_down)
        else $error("sidetone on with key up");

    // No character code without a completed character.
    a_code_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_char_valid) |-> (o_char_code == '0))
        else $error("character code set without a character");

    // A waiting result is refused no new item.
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the iambic keyer with decoder
// Drives paddle scans through the input channel and checks every result item
// against an in-bench model of the keyer state machine and Morse decoder.
// Registers are set over the APB port, read back, and swept from the fastest
// speed down to a dit time of 1200; both iambic modes are tested.
// ----------------------------------------------------------------------------
module tb;
    import ikd_pkg::*;

    // The decoder table of the model. Entry i of the code list and entry i of
    // the character string belong together; the first entry is the top byte.
    localparam int MORSE_N = 41;
    localparam logic [MORSE_N*8-1:0] MORSE_CODES = {
        8'hF9, 8'hE8, 8'hEA, 8'hF4, 8'hFC, 8'hE2, 8'hF6, 8'hE0, 8'hF8, 8'hE7,
        8'hF5, 8'hE4, 8'hFB, 8'hFA, 8'hF7, 8'hE6, 8'hED, 8'hF2, 8'hF0, 8'hFD,
        8'hF1, 8'hE1, 8'hF3, 8'hE9, 8'hEB, 8'hEC, 8'hDF, 8'hCF, 8'hC7, 8'hC3,
        8'hC1, 8'hC0, 8'hD0, 8'hD8, 8'hDC, 8'hDE, 8'hD2, 8'h8C, 8'hCA, 8'h00,
        8'hEF
    };
    localparam logic [MORSE_N*8-1:0] MORSE_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789/?*# ";
    localparam logic [CHAR_W-1:0] ASCII_QUESTION = 7'h3F;

    typedef struct packed {
        logic              key_down;
        logic              sidetone_on;
        logic              char_valid;
        logic [CHAR_W-1:0] char_code;
    } t_keying_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_dit_pressed;
    logic               i_dah_pressed;
    logic               i_tick;
    logic               o_out_valid;
    logic               i_out_ready;
    logic               o_key_down;
    logic               o_sidetone_on;
    logic               o_char_valid;
    logic [CHAR_W-1:0]  o_char_code;

    // Model copy of the configuration registers.
    logic [DIT_W-1:0]   cfg_dit_time;
    logic               cfg_mode_b;
    logic               cfg_sidetone;

    // Model copy of the keyer state.
    t_keyer_state       kst;
    logic               dit_latched;
    logic               dah_latched;
    logic               dit_running;
    logic [TIMER_W-1:0] interval_left;
    logic [CODE_W-1:0]  code_byte;
    logic               key_lvl;

    // Results predicted for accepted scans, oldest first.
    t_keying_result     predicted_keying[$];

    int                 send_gap_pct;
    int                 recv_stall_pct;
    int                 mismatches;
    int                 scans_sent;
    int                 chars_seen;
    int                 keyed_results;
    int                 settings_used;

    iambic_keyer_with_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_dit_pressed  (i_dit_pressed),
        .i_dah_pressed  (i_dah_pressed),
        .i_tick         (i_tick),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_down     (o_key_down),
        .o_sidetone_on  (o_sidetone_on),
        .o_char_valid   (o_char_valid),
        .o_char_code    (o_char_code)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Keyer model
    // ------------------------------------------------------------------------

    function automatic logic [CHAR_W-1:0] morse_ascii(input logic [CODE_W-1:0] pattern);
        for (int i = 0; i < MORSE_N; i++) begin
            if (MORSE_CODES[(MORSE_N-1-i)*8 +: 8] == pattern) begin
                return MORSE_CHARS[(MORSE_N-1-i)*8 +: CHAR_W];
            end
        end
        return ASCII_QUESTION;
    endfunction

    // A tick with the counter already at zero ends the interval; any other
    // tick counts down. An interval of D therefore lasts D+1 ticks.
    function automatic logic interval_done(input logic tick);
        if (!tick) begin
            return 1'b0;
        end
        if (interval_left == '0) begin
            return 1'b1;
        end
        interval_left = interval_left - TIMER_W'(1);
        return 1'b0;
    endfunction

    function automatic void latch_paddles(input logic dit, input logic dah);
        if (dit) begin
            dit_latched = 1'b1;
        end
        if (dah) begin
            dah_latched = 1'b1;
        end
    endfunction

    function automatic void reset_keyer_model();
        cfg_dit_time  = DIT_TIME_RESET;
        cfg_mode_b    = 1'b1;
        cfg_sidetone  = 1'b0;
        kst           = ST_IDLE;
        dit_latched   = 1'b0;
        dah_latched   = 1'b0;
        dit_running   = 1'b0;
        interval_left = '0;
        code_byte     = CODE_START;
        key_lvl       = 1'b0;
    endfunction

    // Advances the model by one scan and returns the result it should give.
    function automatic t_keying_result advance_keyer(input logic dit, input logic dah,
                                                     input logic tick);
        t_keying_result res;
        res = '0;
        case (kst)
            ST_CHK_DIT: begin
                if (dit_latched) begin
                    dit_running   = 1'b1;
                    interval_left = TIMER_W'(cfg_dit_time);
                    code_byte     = {code_byte[CODE_W-2:0], 1'b0};
                    kst           = ST_KEYED_PREP;
                end else begin
                    kst = ST_CHK_DAH;
                end
            end
            ST_CHK_DAH: begin
                if (dah_latched) begin
                    interval_left = TIMER_W'(cfg_dit_time * 3);
                    code_byte     = {code_byte[CODE_W-2:0], 1'b1};
                    kst           = ST_KEYED_PREP;
                end else begin
                    interval_left = TIMER_W'(cfg_dit_time * 2);
                    kst           = ST_PRE_IDLE;
                end
            end
            ST_KEYED_PREP: begin
                key_lvl     = 1'b1;
                dit_latched = 1'b0;
                dah_latched = 1'b0;
                kst         = ST_KEYED;
            end
            ST_KEYED: begin
                if (interval_done(tick)) begin
                    key_lvl       = 1'b0;
                    interval_left = TIMER_W'(cfg_dit_time);
                    kst           = ST_INTER_ELEMENT;
                end else if (cfg_mode_b) begin
                    latch_paddles(dit, dah);
                end
            end
            ST_INTER_ELEMENT: begin
                latch_paddles(dit, dah);
                if (interval_done(tick)) begin
                    if (dit_running) begin
                        dit_latched = 1'b0;
                        dit_running = 1'b0;
                        kst         = ST_CHK_DAH;
                    end else begin
                        dah_latched   = 1'b0;
                        interval_left = TIMER_W'(cfg_dit_time * 2);
                        kst           = ST_PRE_IDLE;
                    end
                end
            end
            ST_PRE_IDLE: begin
                if (dit || dah || dit_latched || dah_latched) begin
                    latch_paddles(dit, dah);
                    kst = ST_CHK_DIT;
                end else if (interval_done(tick)) begin
                    res.char_valid = 1'b1;
                    res.char_code  = morse_ascii(code_byte);
                    kst            = ST_IDLE;
                end
            end
            default: begin
                if (dit || dah || dit_latched || dah_latched) begin
                    latch_paddles(dit, dah);
                    code_byte = CODE_START;
                    kst       = ST_CHK_DIT;
                end else begin
                    kst = ST_IDLE;
                end
            end
        endcase
        res.key_down    = key_lvl;
        res.sidetone_on = key_lvl & cfg_sidetone;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every accepted result item is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_keying_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_keying.size() == 0) begin
                $error("result item arrived with no scan waiting for it");
                mismatches++;
            end else begin
                want = predicted_keying.pop_front();
                if (o_key_down !== want.key_down) begin
                    $error("key_down: expected %0d, got %0d", want.key_down, o_key_down);
                    mismatches++;
                end
                if (o_sidetone_on !== want.sidetone_on) begin
                    $error("sidetone_on: expected %0d, got %0d",
                           want.sidetone_on, o_sidetone_on);
                    mismatches++;
                end
                if (o_char_valid !== want.char_valid) begin
                    $error("char_valid: expected %0d, got %0d",
                           want.char_valid, o_char_valid);
                    mismatches++;
                end
                if (o_char_code !== want.char_code) begin
                    $error("char_code: expected 0x%02h, got 0x%02h",
                           want.char_code, o_char_code);
                    mismatches++;
                end
                if (want.char_valid) begin
                    chars_seen++;
                end
                if (want.key_down) begin
                    keyed_results++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one scan, with a random gap ahead of it, and predicts its result
    // once it is taken. Valid stays high into the next scan when no gap falls.
    task automatic send_scan(input logic dit, input logic dah, input logic tick);
        t_keying_result res;
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_dit_pressed <= dit;
        i_dah_pressed <= dah;
        i_tick        <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        res = advance_keyer(dit, dah, tick);
        predicted_keying.push_back(res);
        scans_sent++;
    endtask

    task automatic hold_paddles(input logic dit, input logic dah, input int count,
                                input int tick_pct);
        repeat (count) send_scan(dit, dah, $urandom_range(99) < tick_pct);
    endtask

    task automatic hold_until_key(input logic dit, input logic dah);
        do send_scan(dit, dah, 1'b1); while (!key_lvl);
    endtask

    task automatic hold_until_code(input logic dit, input logic dah,
                                   input logic [CODE_W-1:0] target);
        do send_scan(dit, dah, 1'b1); while (code_byte != target);
    endtask

    // Paddles released and a tick on every scan until the character is out.
    task automatic release_to_idle();
        do send_scan(1'b0, 1'b0, 1'b1); while (kst != ST_IDLE);
    endtask

    // Waits until every predicted result has come back and the single result stage is surely empty.
    task automatic settle_keyer();
        i_in_valid <= 1'b0;
        while (predicted_keying.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------

    task automatic check_reg(input t_reg_index idx);
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] got;
        want = '0;
        case (idx)
            REG_DIT_TIME: want[DIT_W-1:0] = cfg_dit_time;
            REG_MODE_B:   want[0] = cfg_mode_b;
            REG_SIDETONE: want[0] = cfg_sidetone;
            default: ;
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            $error("register %s: expected 0x%08h, got 0x%08h", idx.name(), want, got);
            mismatches++;
        end
    endtask

    // Writes one register once the keyer has no item in flight, then reads it
    // back, unless it is the unused slot; the block drops bits above its width.
    task automatic write_reg(input t_reg_index idx, input logic [DATA_W-1:0] value);
        settle_keyer();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DIT_TIME: cfg_dit_time = value[DIT_W-1:0];
            REG_MODE_B:   cfg_mode_b   = value[0];
            REG_SIDETONE: cfg_sidetone = value[0];
            default: ;
        endcase
        settings_used++;
        if (idx != REG_UNUSED) begin
            check_reg(idx);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values, masking of upper bits, and the unused address.
    task automatic test_register_access();
        check_reg(REG_DIT_TIME);
        check_reg(REG_MODE_B);
        check_reg(REG_SIDETONE);
        write_reg(REG_DIT_TIME, 32'hFFFF_F805);
        write_reg(REG_MODE_B, 32'hFFFF_FFFE);
        write_reg(REG_SIDETONE, 32'h8000_0001);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        check_reg(REG_DIT_TIME);
        check_reg(REG_MODE_B);
        check_reg(REG_SIDETONE);
    endtask

    // Zero dit time, where every interval ends on its first tick: a lone dit,
    // a lone dah, scans without a tick, and a squeeze of both paddles.
    task automatic test_fast_characters();
        write_reg(REG_DIT_TIME, 32'd0);
        write_reg(REG_MODE_B, 32'd0);
        write_reg(REG_SIDETONE, 32'd1);
        hold_paddles(1'b1, 1'b0, 1, 100);
        release_to_idle();
        hold_paddles(1'b0, 1'b1, 1, 100);
        hold_paddles(1'b0, 1'b0, 3, 0);
        release_to_idle();
        hold_paddles(1'b1, 1'b1, 12, 100);
        release_to_idle();
    endtask

    // Seven dits shift the code byte down to zero, which decodes as the hash
    // sign. More elements shift bits out the top and leave an unknown code.
    task automatic test_code_byte_limits();
        hold_until_code(1'b1, 1'b0, 8'h00);
        release_to_idle();
        hold_until_code(1'b1, 1'b0, 8'h00);
        hold_until_code(1'b0, 1'b1, 8'h01);
        release_to_idle();
    endtask

    // The sidetone enable is switched while the key is held down between
    // scans; the sidetone level must follow on the very next result.
    task automatic test_live_sidetone();
        write_reg(REG_DIT_TIME, 32'd2);
        write_reg(REG_SIDETONE, 32'd0);
        hold_until_key(1'b0, 1'b1);
        write_reg(REG_SIDETONE, 32'd1);
        hold_paddles(1'b0, 1'b0, 2, 0);
        write_reg(REG_SIDETONE, 32'd0);
        hold_paddles(1'b0, 1'b0, 1, 0);
        release_to_idle();
    endtask

    // Squeeze keying and a dit tapped during a dah, first in mode A, where
    // the tap is lost, then in mode B, where it is latched.
    task automatic test_iambic_modes();
        write_reg(REG_DIT_TIME, 32'd1);
        for (int mode = 0; mode < 2; mode++) begin
            write_reg(REG_MODE_B, mode);
            hold_paddles(1'b1, 1'b1, 16, 100);
            release_to_idle();
            hold_until_key(1'b0, 1'b1);
            hold_paddles(1'b1, 1'b0, 2, 0);
            release_to_idle();
        end
    endtask

    // One dit at a dit time of 1200: about twelve hundred keyed scans. The dit
    // time is cut back while the key is still down, so the spaces that follow
    // the element stay short.
    task automatic test_slowest_speed();
        write_reg(REG_DIT_TIME, 32'd1200);
        write_reg(REG_SIDETONE, 32'd1);
        hold_until_key(1'b1, 1'b0);
        hold_paddles(1'b0, 1'b0, 1200, 100);
        write_reg(REG_DIT_TIME, 32'd2);
        release_to_idle();
    endtask

    // Small dit times most of the time so characters finish often; upper
    // register bits carry random noise that the block must drop.
    task automatic randomize_settings();
        int pick;
        logic [DATA_W-1:0] value;
        pick  = $urandom_range(99);
        value = $urandom & ~32'h7FF;
        if (pick < 15) begin
            value[DIT_W-1:0] = '0;
        end else if (pick < 85) begin
            value[DIT_W-1:0] = DIT_W'($urandom_range(1, 3));
        end else begin
            value[DIT_W-1:0] = DIT_W'($urandom_range(4, 12));
        end
        write_reg(REG_DIT_TIME, value);
        write_reg(REG_MODE_B, $urandom);
        write_reg(REG_SIDETONE, $urandom);
    endtask

    // Mostly held paddle patterns of random length and tick density, so the
    // keyer walks through whole characters; the rest is single-scan noise.
    task automatic test_random_traffic(input int n_scans, input int gap_pct,
                                       input int stall_pct);
        int first;
        int pattern;
        int len;
        int rate;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (2) begin
            randomize_settings();
            first = scans_sent;
            while (scans_sent - first < n_scans / 2) begin
                if ($urandom_range(99) < 85) begin
                    pattern = $urandom_range(3);
                    len     = $urandom_range(1, 6 * (cfg_dit_time + 1) + 4);
                    rate    = $urandom_range(40, 100);
                    hold_paddles(pattern[0], pattern[1], len, rate);
                end else begin
                    send_scan(1'($urandom_range(1)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        mismatches     = 0;
        scans_sent     = 0;
        chars_seen     = 0;
        keyed_results  = 0;
        settings_used  = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        reset_keyer_model();

        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_dit_pressed <= 1'b0;
        i_dah_pressed <= 1'b0;
        i_tick        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_access();
        test_fast_characters();
        test_code_byte_limits();
        test_live_sidetone();
        test_iambic_modes();
        test_slowest_speed();
        test_random_traffic(300, 30, 73);
        test_random_traffic(300, 73, 30);
        test_random_traffic(300, 0, 0);

        settle_keyer();
        $display("Sent %0d paddle scans across %0d register writes, from zero dit time",
                 scans_sent, settings_used);
        $display("to 1200 ms in both modes; %0d characters decoded, %0d keyed results.",
                 chars_seen, keyed_results);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
